### rtl/core/assert_macros.svh
// Assertion macros for the RTL files; gray_emboss_3x3_top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_ON(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/core/ge3_pkg.sv
`timescale 1ns / 1ps

package ge3_pkg;

    localparam int PIX_W  = 8;
    localparam int WSUM_W = 18;
    localparam int RECIP_W = 19;
    localparam int PROD_W = WSUM_W + RECIP_W;
    localparam int SUM_W  = 11;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [WSUM_W-1:0] t_wsum;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [3:0]        t_tap;

    localparam t_wsum R_COEF = 18'd299;
    localparam t_wsum G_COEF = 18'd587;
    localparam t_wsum B_COEF = 18'd114;

    // floor(x / 1000) for x up to 255000 is (x * RECIP) >> RECIP_SHIFT.
    localparam logic [RECIP_W-1:0] RECIP = 19'd268436;
    localparam int RECIP_SHIFT = 28;

    localparam t_tap LAST_TAP = 4'd8;
    localparam t_sum BIAS     = 11'd128;

    typedef enum logic [1:0] {
        W_ZERO,
        W_PLUS,
        W_MINUS
    } t_weight;

    function automatic t_weight tap_weight(input t_tap tap);
        t_weight w;
        unique case (tap)
            4'd0, 4'd1, 4'd3: w = W_MINUS;
            4'd5, 4'd7, 4'd8: w = W_PLUS;
            default:          w = W_ZERO;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/ge3_gray.sv
`timescale 1ns / 1ps

module ge3_gray (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ge3_pkg::t_pix i_red,
    input  ge3_pkg::t_pix i_green,
    input  ge3_pkg::t_pix i_blue,
    output logic          o_valid,
    input  logic          i_ready,
    output ge3_pkg::t_pix o_gray
);
    import ge3_pkg::*;

    logic  r_s1_valid, r_s2_valid, r_s3_valid;
    t_pix  r_red, r_green, r_blue;
    t_wsum r_wsum;
    t_pix  r_gray;

    logic  s3_load_ok, s2_load_ok, s1_load_ok;
    t_wsum n_wsum;
    logic [PROD_W-1:0] prod;

    assign s3_load_ok = !r_s3_valid || i_ready;
    assign s2_load_ok = !r_s2_valid || s3_load_ok;
    assign s1_load_ok = !r_s1_valid || s2_load_ok;
    assign o_ready    = s1_load_ok;

    assign n_wsum = {{(WSUM_W-PIX_W){1'b0}}, r_red}   * R_COEF
                  + {{(WSUM_W-PIX_W){1'b0}}, r_green} * G_COEF
                  + {{(WSUM_W-PIX_W){1'b0}}, r_blue}  * B_COEF;

    assign prod = {{RECIP_W{1'b0}}, r_wsum} * {{WSUM_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_load_ok) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load_ok) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_load_ok) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load_ok && i_valid) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (s2_load_ok && r_s1_valid) begin
            r_wsum <= n_wsum;
        end
        if (s3_load_ok && r_s2_valid) begin
            r_gray <= prod[RECIP_SHIFT +: PIX_W];
        end
    end

    assign o_valid = r_s3_valid;
    assign o_gray  = r_gray;

endmodule

### rtl/core/gray_emboss_3x3_top.sv
`timescale 1ns / 1ps
// Takes one pixel per cycle while o_ready is high; the ninth pixel of a window
// passes the three gray stages into the result register, so one result comes
// out for every nine pixels. Throughput is bound only by the output handshake;
// the pipeline holds up to four items: three pixel stages and the result register.
// Synchronous active-low reset empties the pipeline and clears the sum and tap.
`include "assert_macros.svh"

module gray_emboss_3x3_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ge3_pkg::t_pix i_red,
    input  ge3_pkg::t_pix i_green,
    input  ge3_pkg::t_pix i_blue,
    output logic          o_valid,
    input  logic          i_ready,
    output ge3_pkg::t_pix o_out_red,
    output ge3_pkg::t_pix o_out_green,
    output ge3_pkg::t_pix o_out_blue
);
    import ge3_pkg::*;

    logic    g_valid, g_ready;
    t_pix    g_gray;
    logic    out_free, take;
    t_weight w;
    t_sum    gray_ext, n_sum, res_sum;
    t_sum    r_sum;
    t_tap    r_tap;
    logic    r_o_valid;
    t_pix    r_res;

    ge3_gray u_gray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (g_valid),
        .i_ready (g_ready),
        .o_gray  (g_gray)
    );

    assign out_free = !r_o_valid || i_ready;
    assign g_ready  = (r_tap != LAST_TAP) || out_free;
    assign take     = g_valid && g_ready;

    assign w        = tap_weight(r_tap);
    assign gray_ext = {{(SUM_W-PIX_W){1'b0}}, g_gray};

    always_comb begin
        unique case (w)
            W_PLUS:  n_sum = r_sum + gray_ext;
            W_MINUS: n_sum = r_sum - gray_ext;
            default: n_sum = r_sum;
        endcase
    end

    assign res_sum = n_sum + BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_tap     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_tap == LAST_TAP) begin
                    r_sum <= '0;
                    r_tap <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_tap <= r_tap + 4'd1;
                end
            end
            if (take && r_tap == LAST_TAP) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_tap == LAST_TAP) begin
            r_res <= res_sum[PIX_W-1:0];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_red   = r_res;
    assign o_out_green = r_res;
    assign o_out_blue  = r_res;

    `ASSERT_ON(a_tap_range, r_tap <= LAST_TAP, "tap counter left the window")
    `ASSERT_ON(a_window_close, take && r_tap == LAST_TAP |=> r_o_valid && r_tap == '0 && r_sum == '0, "window did not close")
    `ASSERT_ON(a_no_drop, r_o_valid && !i_ready |-> !(take && r_tap == LAST_TAP), "result overwritten while waiting")
    `ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !r_o_valid && r_tap == '0 && r_sum == '0, "reset did not clear state")

endmodule
